### rtl/core/mnt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mnt_pkg
// shared constants and codes of the multiscale niblack threshold block
// ----------------------------------------------------------------------------
package mnt_pkg;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int WINDOW_STEPS = 6;

    localparam int TSTRIDE  = MAX_WIDTH + 1;
    localparam int TSIZE    = (MAX_WIDTH + 1) * (MAX_HEIGHT + 1);
    localparam int TADDR_W  = $clog2(TSIZE);
    localparam int PADDR_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HALF     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 2'd3;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [7:0] LEVEL_DARK      = 8'd0;
    localparam logic [7:0] LEVEL_FLAT_DARK = 8'd64;
    localparam logic [7:0] LEVEL_UNSURE    = 8'd128;
    localparam logic [7:0] LEVEL_BRIGHT    = 8'd255;

endpackage
`default_nettype wire

### rtl/core/mnt_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mnt_req_if
// request channel: load or query item with valid/ready handshake
// ----------------------------------------------------------------------------
interface mnt_req_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] pixel;
    logic [7:0] col;
    logic [7:0] row;

    modport source (output valid, output cmd, output pixel, output col, output row,
                    input ready);
    modport sink   (input valid, input cmd, input pixel, input col, input row,
                    output ready);
endinterface
`default_nettype wire

### rtl/core/mnt_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mnt_rsp_if
// response channel: classification level with valid/ready handshake
// ----------------------------------------------------------------------------
interface mnt_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface
`default_nettype wire

### rtl/core/multiscale_niblack_threshold.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multiscale_niblack_threshold
// niblack threshold over integral tables with up to six growing windows
// ----------------------------------------------------------------------------
// After reset the block sweeps both integral tables to zero, one entry a
// cycle, and accepts no item until done; config writes are taken at any
// time. A load item is a read of the row above, then a write back. In a
// query each window tried is set by four corner reads on the single table
// read port, a 32-step square root run alongside the 32-step mean
// division, and a second 32-step division for sigma. Results wait in an
// output register.
// ----------------------------------------------------------------------------
module multiscale_niblack_threshold (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    mnt_req_if.sink                              req,
    mnt_rsp_if.source                            rsp,
    input  wire logic                            cfg_we,
    input  wire logic [mnt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mnt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mnt_pkg::*;

    typedef enum logic [15:0] {
        ST_IDLE  = 16'b0000_0000_0000_0001,
        ST_CLEAR = 16'b0000_0000_0000_0010,
        ST_LD_RD = 16'b0000_0000_0000_0100,
        ST_LD_WR = 16'b0000_0000_0000_1000,
        ST_Q_PIX = 16'b0000_0000_0001_0000,
        ST_Q_GEO = 16'b0000_0000_0010_0000,
        ST_Q_RD  = 16'b0000_0000_0100_0000,
        ST_Q_SUM = 16'b0000_0000_1000_0000,
        ST_Q_MUL = 16'b0000_0001_0000_0000,
        ST_Q_DIF = 16'b0000_0010_0000_0000,
        ST_Q_RT  = 16'b0000_0100_0000_0000,
        ST_Q_SIG = 16'b0000_1000_0000_0000,
        ST_Q_DIV = 16'b0001_0000_0000_0000,
        ST_Q_KS  = 16'b0010_0000_0000_0000,
        ST_Q_CMP = 16'b0100_0000_0000_0000,
        ST_Q_DON = 16'b1000_0000_0000_0000
    } state_t;

    localparam logic [TADDR_W-1:0] CLR_LAST = TADDR_W'(TSIZE - 1);

    // memories
    logic [7:0]  pix_mem [MAX_WIDTH * MAX_HEIGHT];
    logic [23:0] sum_mem [TSIZE];
    logic [31:0] sq_mem  [TSIZE];

    // registers
    state_t               state_reg, state_next;
    logic [8:0]           width_reg, width_next;
    logic [8:0]           height_reg, height_next;
    logic [3:0]           minhw_reg, minhw_next;
    logic [15:0]          gain_reg, gain_next;
    logic [TADDR_W-1:0]   clr_reg, clr_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic [2:0]           k_reg, k_next;
    logic [COL_W-1:0]     load_col_reg, load_col_next;
    logic [ROW_W-1:0]     load_row_reg, load_row_next;
    logic [15:0]          rs_reg, rs_next;
    logic [23:0]          rsq_reg, rsq_next;
    logic [7:0]           pixel_reg, pixel_next;
    logic [7:0]           col_reg, col_next;
    logic [7:0]           row_reg, row_next;
    logic [8:0]           x0_reg, x0_next, x1_reg, x1_next;
    logic [8:0]           y0_reg, y0_next, y1_reg, y1_next;
    logic [23:0]          s_reg, s_next;
    logic [31:0]          q_reg, q_next;
    logic [16:0]          n_reg, n_next;
    logic [48:0]          nq_reg, nq_next;
    logic [47:0]          ss_reg, ss_next;
    logic [63:0]          sqv_reg, sqv_next;
    logic [33:0]          sqr_reg, sqr_next;
    logic [31:0]          root_reg, root_next;
    logic [31:0]          dvn_reg, dvn_next;
    logic [16:0]          dvr_reg, dvr_next;
    logic [31:0]          e8_reg, e8_next;
    logic [47:0]          ks_reg, ks_next;
    logic [7:0]           lvl_reg, lvl_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [7:0]           level_reg, level_next;

    // memory ports
    logic [7:0]           pix_rd_reg;
    logic [23:0]          sum_rd_reg;
    logic [31:0]          sq_rd_reg;
    logic                 pix_we, pix_re, tbl_we;
    logic [PADDR_W-1:0]   pix_addr;
    logic [TADDR_W-1:0]   tbl_waddr, tbl_raddr;
    logic [23:0]          sum_wdata;
    logic [31:0]          sq_wdata;

    function automatic logic [TADDR_W-1:0] tbl_addr(input logic [8:0] y, input logic [8:0] x);
        tbl_addr = TADDR_W'(y) * TADDR_W'(TSTRIDE) + TADDR_W'(x);
    endfunction

    function automatic logic [8:0] sat_size(input logic [8:0] v, input int lim);
        if (v == 9'd0) sat_size = 9'd1;
        else if (int'(v) > lim) sat_size = 9'(lim);
        else sat_size = v;
    endfunction

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.level = level_reg;

    always_comb
    begin
        logic [8:0]  w, h, c9, r9, wing, x, y;
        logic [9:0]  xe, ye;
        logic        clr_sum;
        logic [15:0] rs_base;
        logic [23:0] rsq_base;
        logic [35:0] sq_t, sq_trial;
        logic [17:0] dv_t;
        logic [3:0]  wmin;
        logic [49:0] lhs_a, rhs_a, lhs_b, rhs_b;

        w = sat_size(width_reg, MAX_WIDTH);
        h = sat_size(height_reg, MAX_HEIGHT);
        wmin = (minhw_reg == 4'd0) ? 4'd1 : minhw_reg;
        c9 = 9'd0; r9 = 9'd0; wing = 9'd0; x = 9'd0; y = 9'd0; xe = 10'd0; ye = 10'd0;
        clr_sum = 1'b0; rs_base = 16'd0; rsq_base = 24'd0;
        sq_t = 36'd0; sq_trial = 36'd0; dv_t = 18'd0;
        lhs_a = 50'd0; rhs_a = 50'd0; lhs_b = 50'd0; rhs_b = 50'd0;

        state_next = state_reg;
        width_next = width_reg; height_next = height_reg;
        minhw_next = minhw_reg; gain_next = gain_reg;
        clr_next = clr_reg; cnt_next = cnt_reg; k_next = k_reg;
        load_col_next = load_col_reg; load_row_next = load_row_reg;
        rs_next = rs_reg; rsq_next = rsq_reg;
        pixel_next = pixel_reg; col_next = col_reg; row_next = row_reg;
        x0_next = x0_reg; x1_next = x1_reg; y0_next = y0_reg; y1_next = y1_reg;
        s_next = s_reg; q_next = q_reg; n_next = n_reg;
        nq_next = nq_reg; ss_next = ss_reg;
        sqv_next = sqv_reg; sqr_next = sqr_reg; root_next = root_reg;
        dvn_next = dvn_reg; dvr_next = dvr_reg;
        e8_next = e8_reg; ks_next = ks_reg; lvl_next = lvl_reg;
        rsp_valid_next = rsp_valid_reg; level_next = level_reg;

        pix_we = 1'b0; pix_re = 1'b0; tbl_we = 1'b0;
        pix_addr = '0; tbl_waddr = '0; tbl_raddr = '0;
        sum_wdata = 24'd0; sq_wdata = 32'd0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_next  = cfg_data[8:0];
                CFG_IMAGE_HEIGHT: height_next = cfg_data[8:0];
                CFG_MIN_HALF:     minhw_next  = cfg_data[3:0];
                CFG_GAIN:         gain_next   = cfg_data[15:0];
                default:          gain_next   = gain_reg;
            endcase
        end

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                tbl_we = 1'b1;
                tbl_waddr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    pixel_next = req.pixel;
                    col_next = req.col;
                    row_next = req.row;
                    state_next = (req.cmd == CMD_QUERY) ? ST_Q_PIX : ST_LD_RD;
                end
            end
            ST_LD_RD:
            begin
                c9 = 9'(load_col_reg);
                r9 = 9'(load_row_reg);
                if (c9 >= w)
                begin
                    c9 = 9'd0;
                    r9 = r9 + 9'd1;
                    clr_sum = 1'b1;
                end
                if (r9 >= h)
                begin
                    r9 = 9'd0;
                end
                rs_base = clr_sum ? 16'd0 : rs_reg;
                rsq_base = clr_sum ? 24'd0 : rsq_reg;
                rs_next = rs_base + 16'(pixel_reg);
                rsq_next = rsq_base + 24'(16'(pixel_reg) * 16'(pixel_reg));
                load_col_next = c9[COL_W-1:0];
                load_row_next = r9[ROW_W-1:0];
                pix_we = 1'b1;
                pix_addr = {r9[ROW_W-1:0], c9[COL_W-1:0]};
                tbl_raddr = tbl_addr(r9, c9 + 9'd1);
                state_next = ST_LD_WR;
            end
            ST_LD_WR:
            begin
                tbl_we = 1'b1;
                tbl_waddr = tbl_addr(9'(load_row_reg) + 9'd1, 9'(load_col_reg) + 9'd1);
                sum_wdata = sum_rd_reg + 24'(rs_reg);
                sq_wdata = sq_rd_reg + 32'(rsq_reg);
                c9 = 9'(load_col_reg) + 9'd1;
                r9 = 9'(load_row_reg);
                if (c9 >= w)
                begin
                    c9 = 9'd0;
                    r9 = r9 + 9'd1;
                    rs_next = 16'd0;
                    rsq_next = 24'd0;
                    if (r9 >= h)
                    begin
                        r9 = 9'd0;
                    end
                end
                load_col_next = c9[COL_W-1:0];
                load_row_next = r9[ROW_W-1:0];
                state_next = ST_IDLE;
            end
            ST_Q_PIX:
            begin
                x = (9'(col_reg) >= w) ? w - 9'd1 : 9'(col_reg);
                y = (9'(row_reg) >= h) ? h - 9'd1 : 9'(row_reg);
                col_next = x[7:0];
                row_next = y[7:0];
                pix_re = 1'b1;
                pix_addr = {y[ROW_W-1:0], x[COL_W-1:0]};
                k_next = 3'd0;
                state_next = ST_Q_GEO;
            end
            ST_Q_GEO:
            begin
                wing = 9'(wmin) << k_reg;
                x = 9'(col_reg);
                y = 9'(row_reg);
                x0_next = (x > wing) ? x - wing : 9'd0;
                y0_next = (y > wing) ? y - wing : 9'd0;
                xe = 10'(x) + 10'(wing) + 10'd1;
                ye = 10'(y) + 10'(wing) + 10'd1;
                x1_next = (xe > 10'(w)) ? w : xe[8:0];
                y1_next = (ye > 10'(h)) ? h : ye[8:0];
                s_next = 24'd0;
                q_next = 32'd0;
                cnt_next = 5'd0;
                state_next = ST_Q_RD;
            end
            ST_Q_RD:
            begin
                unique case (cnt_reg[1:0])
                    2'd0:    tbl_raddr = tbl_addr(y1_reg, x1_reg);
                    2'd1:    tbl_raddr = tbl_addr(y0_reg, x1_reg);
                    2'd2:    tbl_raddr = tbl_addr(y1_reg, x0_reg);
                    default: tbl_raddr = tbl_addr(y0_reg, x0_reg);
                endcase
                // corners above right and below left subtract
                if (cnt_reg == 5'd2 || cnt_reg == 5'd3)
                begin
                    s_next = s_reg - sum_rd_reg;
                    q_next = q_reg - sq_rd_reg;
                end
                else if (cnt_reg != 5'd0)
                begin
                    s_next = s_reg + sum_rd_reg;
                    q_next = q_reg + sq_rd_reg;
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd4)
                begin
                    state_next = ST_Q_SUM;
                end
            end
            ST_Q_SUM:
            begin
                n_next = 17'(x1_reg - x0_reg) * 17'(y1_reg - y0_reg);
                state_next = ST_Q_MUL;
            end
            ST_Q_MUL:
            begin
                nq_next = 49'(n_reg) * 49'(q_reg);
                ss_next = 48'(s_reg) * 48'(s_reg);
                state_next = ST_Q_DIF;
            end
            ST_Q_DIF:
            begin
                sqv_next = (nq_reg > 49'(ss_reg)) ? {48'(nq_reg - 49'(ss_reg)), 16'd0} : 64'd0;
                sqr_next = 34'd0;
                root_next = 32'd0;
                dvn_next = {s_reg, 8'd0};
                dvr_next = 17'd0;
                cnt_next = 5'd0;
                state_next = ST_Q_RT;
            end
            ST_Q_RT:
            begin
                // one root bit and one mean quotient bit per cycle
                sq_t = {sqr_reg, sqv_reg[63:62]};
                sq_trial = {2'b00, root_reg, 2'b01};
                if (sq_t >= sq_trial)
                begin
                    sqr_next = 34'(sq_t - sq_trial);
                    root_next = {root_reg[30:0], 1'b1};
                end
                else
                begin
                    sqr_next = sq_t[33:0];
                    root_next = {root_reg[30:0], 1'b0};
                end
                sqv_next = {sqv_reg[61:0], 2'b00};
                dv_t = {dvr_reg, dvn_reg[31]};
                if (dv_t >= 18'(n_reg))
                begin
                    dvr_next = 17'(dv_t - 18'(n_reg));
                    dvn_next = {dvn_reg[30:0], 1'b1};
                end
                else
                begin
                    dvr_next = dv_t[16:0];
                    dvn_next = {dvn_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = ST_Q_SIG;
                end
            end
            ST_Q_SIG:
            begin
                e8_next = dvn_reg;
                dvn_next = root_reg;
                dvr_next = 17'd0;
                cnt_next = 5'd0;
                state_next = ST_Q_DIV;
            end
            ST_Q_DIV:
            begin
                dv_t = {dvr_reg, dvn_reg[31]};
                if (dv_t >= 18'(n_reg))
                begin
                    dvr_next = 17'(dv_t - 18'(n_reg));
                    dvn_next = {dvn_reg[30:0], 1'b1};
                end
                else
                begin
                    dvr_next = dv_t[16:0];
                    dvn_next = {dvn_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = ST_Q_KS;
                end
            end
            ST_Q_KS:
            begin
                ks_next = 48'(gain_reg) * 48'(dvn_reg);
                state_next = ST_Q_CMP;
            end
            ST_Q_CMP:
            begin
                lhs_a = (50'(pix_rd_reg) + 50'd1) * 50'd16777216 + 50'(ks_reg);
                rhs_a = {2'b00, e8_reg, 16'd0} + 50'd8388608;
                lhs_b = 50'(pix_rd_reg) * 50'd16777216;
                rhs_b = {2'b00, e8_reg, 16'd0} + 50'(ks_reg) + 50'd8388608;
                state_next = ST_Q_DON;
                priority if (k_reg >= 3'd2 && ks_reg < 48'd67108864)
                begin
                    lvl_next = (e8_reg > 32'd32768) ? LEVEL_BRIGHT : LEVEL_FLAT_DARK;
                end
                else if (lhs_a <= rhs_a)
                begin
                    lvl_next = LEVEL_DARK;
                end
                else if (lhs_b > rhs_b)
                begin
                    lvl_next = LEVEL_BRIGHT;
                end
                else if (k_reg == 3'(WINDOW_STEPS - 1))
                begin
                    lvl_next = LEVEL_UNSURE;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                    state_next = ST_Q_GEO;
                end
            end
            ST_Q_DON:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    level_next = lvl_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            width_reg     <= 9'd256;
            height_reg    <= 9'd256;
            minhw_reg     <= 4'd5;
            gain_reg      <= 16'd13107;
            clr_reg       <= '0;
            cnt_reg       <= 5'd0;
            k_reg         <= 3'd0;
            load_col_reg  <= '0;
            load_row_reg  <= '0;
            rs_reg        <= 16'd0;
            rsq_reg       <= 24'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            minhw_reg     <= minhw_next;
            gain_reg      <= gain_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            load_col_reg  <= load_col_next;
            load_row_reg  <= load_row_next;
            rs_reg        <= rs_next;
            rsq_reg       <= rsq_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        x0_reg    <= x0_next;
        x1_reg    <= x1_next;
        y0_reg    <= y0_next;
        y1_reg    <= y1_next;
        s_reg     <= s_next;
        q_reg     <= q_next;
        n_reg     <= n_next;
        nq_reg    <= nq_next;
        ss_reg    <= ss_next;
        sqv_reg   <= sqv_next;
        sqr_reg   <= sqr_next;
        root_reg  <= root_next;
        dvn_reg   <= dvn_next;
        dvr_reg   <= dvr_next;
        e8_reg    <= e8_next;
        ks_reg    <= ks_next;
        lvl_reg   <= lvl_next;
        level_reg <= level_next;
    end

    // pixel store
    always_ff @(posedge clk)
    begin
        if (pix_we)
        begin
            pix_mem[pix_addr] <= pixel_reg;
        end
        if (pix_re)
        begin
            pix_rd_reg <= pix_mem[pix_addr];
        end
    end

    // integral tables
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            sum_mem[tbl_waddr] <= sum_wdata;
            sq_mem[tbl_waddr]  <= sq_wdata;
        end
        sum_rd_reg <= sum_mem[tbl_raddr];
        sq_rd_reg  <= sq_mem[tbl_raddr];
    end

    a_no_item_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !req.ready)
        else $error("item accepted during table clear");

    a_tbl_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> (state_reg == ST_CLEAR || state_reg == ST_LD_WR))
        else $error("table written outside load or clear");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_Q_DON))
        else $error("result raised outside query completion");

    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg < 3'(WINDOW_STEPS))
        else $error("window step out of range");

endmodule
`default_nettype wire
